### rtl/core/eti_pkg.sv
package eti_pkg;

	// data format: signed fixed point with FRAC_BITS fraction bits
	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 28;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int WIDE_W    = PROD_W + 2;

	// iteration count and limit
	localparam int CNT_W          = 8;
	localparam int MAX_ITER_LIMIT = 128;
	localparam logic [CNT_W-1:0] LIMIT_MAX  = CNT_W'(MAX_ITER_LIMIT);
	localparam logic [CNT_W-1:0] ITER_RESET = CNT_W'(100);

	// number of iteration cells in the ring
	localparam int CELL_COUNT = 4;

	// escape when |z|^2 >= 4, compared at product scale 2^(2F)
	localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE     = 2'd0,
		REG_C_REAL   = 2'd1,
		REG_C_IMAG   = 2'd2,
		REG_MAX_ITER = 2'd3
	} cfg_reg_t;

	// token handed from cell to cell
	typedef struct packed {
		logic                     valid;
		logic                     done;
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
		logic [CNT_W-1:0]         count;
	} tok_t;

	// clamp a wide signed value into the data range
	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'({1'b0, {(DATA_W-1){1'b1}}});
		lo = -hi - WIDE_W'(1);
		if (v > hi) begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return v[DATA_W-1:0];
		end
	endfunction

endpackage

### rtl/core/escape_time_fractal_iteration_core.sv
// channel   direction  handshake               payload
// in        request    in_valid / in_ready     point_real, point_imag
// out       result     out_valid / out_ready   iteration_count
// cfg       write      cfg_we                  cfg_index, cfg_data
//
// A ring of CELL_COUNT iteration cells does one iteration per cell, and a point goes round
// the four-cell ring until it escapes or reaches its limit; each cell holds three multipliers.
// One point is in flight at a time; in_ready is high once the result has moved to the output
// register. A finished token circles the ring while that register is still full. Reset clears
// config to defaults, empties the ring and clears the busy and output valid flags.
module escape_time_fractal_iteration_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [eti_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [eti_pkg::DATA_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [eti_pkg::DATA_W-1:0]    point_real,
	input  logic signed [eti_pkg::DATA_W-1:0]    point_imag,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [eti_pkg::CNT_W-1:0]            iteration_count
);

	logic                              mode_q;
	logic signed [eti_pkg::DATA_W-1:0] jc_re_q;
	logic signed [eti_pkg::DATA_W-1:0] jc_im_q;
	logic [eti_pkg::CNT_W-1:0]         max_iter_q;

	logic                              busy_q;
	logic signed [eti_pkg::DATA_W-1:0] c_re_q;
	logic signed [eti_pkg::DATA_W-1:0] c_im_q;
	logic [eti_pkg::CNT_W-1:0]         limit_q;
	logic                              res_valid_q;
	logic [eti_pkg::CNT_W-1:0]         res_q;

	logic                              accept;
	logic                              load_res;
	logic [eti_pkg::CNT_W-1:0]         limit_nxt;
	eti_pkg::tok_t                     tok_last;
	eti_pkg::tok_t                     tok [eti_pkg::CELL_COUNT+1];
	logic [eti_pkg::CELL_COUNT-1:0]    ring_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			jc_re_q    <= '0;
			jc_im_q    <= '0;
			max_iter_q <= eti_pkg::ITER_RESET;
		end else if (cfg_we) begin
			unique case (eti_pkg::cfg_reg_t'(cfg_index))
				eti_pkg::REG_MODE:     mode_q     <= cfg_data[0];
				eti_pkg::REG_C_REAL:   jc_re_q    <= cfg_data;
				eti_pkg::REG_C_IMAG:   jc_im_q    <= cfg_data;
				eti_pkg::REG_MAX_ITER: max_iter_q <= cfg_data[eti_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// request side
	assign in_ready  = !busy_q;
	assign accept    = in_valid && in_ready;
	assign tok_last  = tok[eti_pkg::CELL_COUNT];
	assign load_res  = tok_last.valid && tok_last.done && (!res_valid_q || out_ready);
	assign limit_nxt = (max_iter_q > eti_pkg::LIMIT_MAX) ? eti_pkg::LIMIT_MAX : max_iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (load_res) begin
			busy_q <= 1'b0;
		end
	end

	// per point constants, held while the point circulates
	always_ff @(posedge clk) begin
		if (accept) begin
			limit_q <= limit_nxt;
			c_re_q  <= mode_q ? jc_re_q : point_real;
			c_im_q  <= mode_q ? jc_im_q : point_imag;
		end
	end

	// ring entry: new point or token coming round again
	always_comb begin
		if (accept) begin
			tok[0].valid = 1'b1;
			tok[0].done  = 1'b0;
			tok[0].re    = point_real;
			tok[0].im    = point_imag;
			tok[0].count = '0;
		end else begin
			tok[0]       = tok_last;
			tok[0].valid = tok_last.valid && !load_res;
		end
	end

	// row of iteration cells
	for (genvar k = 0; k < eti_pkg::CELL_COUNT; k++) begin : g_cell
		eti_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[k]),
			.c_re    (c_re_q),
			.c_im    (c_im_q),
			.limit   (limit_q),
			.tok_out (tok[k+1])
		);
		assign ring_valid[k] = tok[k+1].valid;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= tok_last.count;
		end
	end

	assign out_valid       = res_valid_q;
	assign iteration_count = res_q;

	// checks
	a_idle_ring_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (ring_valid == '0))
		else $error("token in ring while idle");

	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ring_valid))
		else $error("more than one token in ring");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("not busy after request");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_last.valid && tok_last.done) |-> (tok_last.count <= limit_q))
		else $error("count beyond limit");

endmodule

### rtl/core/eti_cell.sv
module eti_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  eti_pkg::tok_t                     tok_in,
	input  logic signed [eti_pkg::DATA_W-1:0] c_re,
	input  logic signed [eti_pkg::DATA_W-1:0] c_im,
	input  logic [eti_pkg::CNT_W-1:0]         limit,
	output eti_pkg::tok_t                     tok_out
);

	logic                              v_s1;
	logic                              done_s1;
	logic [eti_pkg::CNT_W-1:0]         cnt_s1;
	logic signed [eti_pkg::PROD_W-1:0] rr_s1;
	logic signed [eti_pkg::PROD_W-1:0] ii_s1;
	logic signed [eti_pkg::PROD_W-1:0] ri_s1;

	logic signed [eti_pkg::PROD_W-1:0] rr_c;
	logic signed [eti_pkg::PROD_W-1:0] ii_c;
	logic signed [eti_pkg::PROD_W-1:0] ri_c;

	logic [eti_pkg::PROD_W-1:0]        mag;
	logic signed [eti_pkg::WIDE_W-1:0] diff;
	logic signed [eti_pkg::WIDE_W-1:0] nr_w;
	logic signed [eti_pkg::WIDE_W-1:0] ni_w;
	logic                              stop;
	eti_pkg::tok_t                     tok_nxt;
	eti_pkg::tok_t                     tok_s2;

	// stage 1: squares and cross product
	assign rr_c = tok_in.re * tok_in.re;
	assign ii_c = tok_in.im * tok_in.im;
	assign ri_c = tok_in.re * tok_in.im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		done_s1 <= tok_in.done;
		cnt_s1  <= tok_in.count;
		rr_s1   <= rr_c;
		ii_s1   <= ii_c;
		ri_s1   <= ri_c;
	end

	// stage 2: escape test and next iterate
	always_comb begin
		mag  = $unsigned(rr_s1) + $unsigned(ii_s1);
		diff = eti_pkg::WIDE_W'(rr_s1) - eti_pkg::WIDE_W'(ii_s1);
		nr_w = (diff >>> eti_pkg::FRAC_BITS) + eti_pkg::WIDE_W'(c_re);
		ni_w = (eti_pkg::WIDE_W'(ri_s1) >>> (eti_pkg::FRAC_BITS - 1))
			+ eti_pkg::WIDE_W'(c_im);
		stop = done_s1 || (cnt_s1 >= limit) || (mag >= eti_pkg::ESC_LIMIT);

		tok_nxt.valid = v_s1;
		tok_nxt.done  = stop;
		tok_nxt.re    = eti_pkg::sat_data(nr_w);
		tok_nxt.im    = eti_pkg::sat_data(ni_w);
		tok_nxt.count = stop ? cnt_s1 : cnt_s1 + eti_pkg::CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2 <= '0;
		end else begin
			tok_s2 <= tok_nxt;
		end
	end

	assign tok_out = tok_s2;

endmodule
